@@ rtl/aets_pkg.sv @@
package aets_pkg;

  localparam int MAX_BLOCK_FRAMES    = 65536;
  localparam int CNT_W               = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int RATE_W              = 18;
  localparam int THR_W               = 16;
  localparam int LEVEL_W             = 17;
  localparam int POS_W               = 48;
  localparam int LEN_W               = 49;
  localparam int RUN_W               = 32;
  localparam int LIM_W               = 23;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 18;

  localparam int DEFAULT_RATE        = 44100;
  localparam int SETTLE_SECONDS      = 4;
  localparam int SILENCE_SECONDS     = 5;
  localparam int NEVER_HEARD_SECONDS = 25;
  localparam int RESET_THRESHOLD     = 80;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WATCH_ENABLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 2'd2;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_SEEK  = 1'b1;

  typedef logic signed [15:0]     sample_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [LEVEL_W-1:0]     level_t;
  typedef logic [THR_W-1:0]       thr_t;
  typedef logic [RUN_W-1:0]       run_t;
  typedef logic [LIM_W-1:0]       lim_t;
  typedef logic [RATE_W-1:0]      rate_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

endpackage

@@ rtl/aets_if.sv @@
interface aets_in_if;
  logic                valid;
  logic                ready;
  logic                command;
  aets_pkg::sample_t   left_sample;
  aets_pkg::sample_t   right_sample;
  logic                block_last;
  aets_pkg::pos_t      position;

  modport source (output valid, command, left_sample, right_sample, block_last, position,
                  input ready);
  modport sink   (input valid, command, left_sample, right_sample, block_last, position,
                  output ready);
endinterface

interface aets_out_if;
  logic            valid;
  logic            ready;
  logic            track_ended;
  logic            heard_sound;
  aets_pkg::len_t  track_length;

  modport source (output valid, track_ended, heard_sound, track_length, input ready);
  modport sink   (input valid, track_ended, heard_sound, track_length, output ready);
endinterface

interface aets_cfg_if;
  logic                 valid;
  logic                 ready;
  aets_pkg::cfg_idx_t   index;
  aets_pkg::cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/audio_end_of_track_silence_detector_unit.sv @@
// End-of-track silence detector for a stereo 16-bit frame stream.
// in_ch carries one frame or one seek command per beat; the last frame of a
// block raises block_last and carries the block start position.
// out_ch returns exactly one result beat per input beat: the sticky end flag,
// the heard flag and the latched track length (zero until the track ends).
// cfg_ch writes sample_rate, watch_enable and level_threshold; it is always
// ready and should only be used while no beat is in flight.
// A beat accepted at one edge is offered on out_ch right after that edge.
// Throughput is one beat per cycle while out_ch takes each result, set by the
// single register stage that holds the result.
// When the receiver stalls, the pending result holds and in_ch stays ready
// only in a cycle where that result is taken, so no beat is lost.
// Synchronous active-low reset clears all counters and flags, empties the
// result register and restores the register defaults (44100 frames per
// second, watch enabled, threshold 80).
module audio_end_of_track_silence_detector_unit (
  input  logic  clk,
  input  logic  rst_n,
  aets_in_if.sink     in_ch,
  aets_out_if.source  out_ch,
  aets_cfg_if.sink    cfg_ch
);
  import aets_pkg::*;

  logic   watch_r;
  thr_t   thr_r;
  lim_t   settle_lim_r;
  lim_t   silence_lim_r;
  lim_t   never_lim_r;
  rate_t  rate_eff;

  run_t   total_r, total_nxt;
  run_t   silent_r, silent_nxt;
  logic   heard_r, heard_nxt;
  logic   ended_r, ended_nxt;
  level_t peak_r, peak_nxt;
  cnt_t   count_r, count_nxt;
  len_t   latch_r, latch_nxt;

  logic   out_valid_r;
  logic   out_ended_r;
  logic   out_heard_r;
  len_t   out_length_r;

  logic   accept;
  level_t abs_l, abs_r, frame_level, peak_upd;
  cnt_t   count_upd;
  logic [RUN_W:0] sum_total, sum_silent;
  run_t   total_sat, silent_sat;
  len_t   len_raw, len_fix;

  assign cfg_ch.ready = 1'b1;
  assign rate_eff = (cfg_ch.data == '0) ? RATE_W'(DEFAULT_RATE) : cfg_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_r       <= 1'b1;
      thr_r         <= THR_W'(RESET_THRESHOLD);
      settle_lim_r  <= LIM_W'(DEFAULT_RATE * SETTLE_SECONDS);
      silence_lim_r <= LIM_W'(DEFAULT_RATE * SILENCE_SECONDS);
      never_lim_r   <= LIM_W'(DEFAULT_RATE * NEVER_HEARD_SECONDS);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SAMPLE_RATE: begin
          settle_lim_r  <= LIM_W'(LIM_W'(rate_eff) * LIM_W'(SETTLE_SECONDS));
          silence_lim_r <= LIM_W'(LIM_W'(rate_eff) * LIM_W'(SILENCE_SECONDS));
          never_lim_r   <= LIM_W'(LIM_W'(rate_eff) * LIM_W'(NEVER_HEARD_SECONDS));
        end
        REG_WATCH_ENABLE: begin
          watch_r <= cfg_ch.data[0];
        end
        REG_LEVEL_THRESHOLD: begin
          thr_r <= cfg_ch.data[THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign abs_l = in_ch.left_sample[15] ? (LEVEL_W'(17'h10000) - {1'b0, in_ch.left_sample})
                                       : {1'b0, in_ch.left_sample};
  assign abs_r = in_ch.right_sample[15] ? (LEVEL_W'(17'h10000) - {1'b0, in_ch.right_sample})
                                        : {1'b0, in_ch.right_sample};
  assign frame_level = (abs_l > abs_r) ? abs_l : abs_r;
  assign peak_upd    = (frame_level > peak_r) ? frame_level : peak_r;
  assign count_upd   = (count_r < CNT_W'(MAX_BLOCK_FRAMES)) ? count_r + 1'b1 : count_r;

  assign sum_total  = {1'b0, total_r} + (RUN_W + 1)'(count_upd);
  assign sum_silent = {1'b0, silent_r} + (RUN_W + 1)'(count_upd);
  assign total_sat  = sum_total[RUN_W] ? '1 : sum_total[RUN_W-1:0];
  assign silent_sat = sum_silent[RUN_W] ? '1 : sum_silent[RUN_W-1:0];

  assign len_raw = LEN_W'(in_ch.position) + LEN_W'(count_upd);
  assign len_fix = (len_raw == '0) ? LEN_W'(1) : len_raw;

  always_comb begin
    total_nxt  = total_r;
    silent_nxt = silent_r;
    heard_nxt  = heard_r;
    ended_nxt  = ended_r;
    peak_nxt   = peak_r;
    count_nxt  = count_r;
    latch_nxt  = latch_r;
    if (in_ch.command == CMD_SEEK) begin
      peak_nxt  = '0;
      count_nxt = '0;
      if (in_ch.position == '0 && !ended_r) begin
        total_nxt  = '0;
        silent_nxt = '0;
        heard_nxt  = 1'b0;
      end
    end else if (!in_ch.block_last) begin
      peak_nxt  = peak_upd;
      count_nxt = count_upd;
    end else begin
      peak_nxt  = '0;
      count_nxt = '0;
      if (watch_r && !ended_r) begin
        total_nxt = total_sat;
        if (peak_upd >= {1'b0, thr_r}) begin
          heard_nxt  = 1'b1;
          silent_nxt = '0;
        end else if (!heard_r) begin
          if (sum_total >= (RUN_W + 1)'(never_lim_r)) begin
            ended_nxt = 1'b1;
            latch_nxt = len_fix;
          end
        end else if (sum_total >= (RUN_W + 1)'(settle_lim_r)) begin
          silent_nxt = silent_sat;
          if (sum_silent >= (RUN_W + 1)'(silence_lim_r)) begin
            ended_nxt = 1'b1;
            latch_nxt = len_fix;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      silent_r    <= '0;
      heard_r     <= 1'b0;
      ended_r     <= 1'b0;
      peak_r      <= '0;
      count_r     <= '0;
      latch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        total_r  <= total_nxt;
        silent_r <= silent_nxt;
        heard_r  <= heard_nxt;
        ended_r  <= ended_nxt;
        peak_r   <= peak_nxt;
        count_r  <= count_nxt;
        latch_r  <= latch_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ended_r  <= ended_nxt;
      out_heard_r  <= heard_nxt;
      out_length_r <= ended_nxt ? latch_nxt : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.track_ended  = out_ended_r;
  assign out_ch.heard_sound  = out_heard_r;
  assign out_ch.track_length = out_length_r;

  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |=> ended_r)
    else $error("end flag dropped after the track ended");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_length_when_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.track_ended) |-> (out_ch.track_length != '0))
    else $error("ended track reports zero length");

  a_length_zero_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.track_ended) |-> (out_ch.track_length == '0))
    else $error("running track reports a length");

endmodule
